### rtl/core/tpim_pkg.sv
// tpim_pkg: shared widths, register codes and request records for the
// tensor permute index map. No dependencies.
package tpim_pkg;

	// axes the size registers can describe
	localparam int unsigned REG_AXES = 4;
	// one division per output axis other than the outermost
	localparam int unsigned NUM_DIVS = REG_AXES - 1;
	localparam int unsigned SIZE_W = 16;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned ACC_W = 64;
	// a source axis may collect up to REG_AXES coordinates
	localparam int unsigned CSUM_W = SIZE_W + 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 3'd5;

	// reset values
	localparam logic [2:0] DIM_COUNT_RST = 3'd4;
	localparam logic [SIZE_W-1:0] SIZE_RST = 16'd1;
	localparam logic [7:0] AXIS_ORDER_RST = 8'd228;

	// request travelling along the divider cells
	typedef struct packed {
		logic valid;
		logic [WORD_W-1:0] word;
		logic [SIZE_W-1:0] rem;
		logic [NUM_DIVS-1:0][SIZE_W-1:0] coord;
	} tpim_div_t;

	// request travelling along the recombination steps
	typedef struct packed {
		logic valid;
		logic err;
		logic [ACC_W-1:0] acc;
		logic [REG_AXES-1:0][CSUM_W-1:0] csum;
	} tpim_acc_t;

endpackage

### rtl/core/tpim_div_cell.sv
// tpim_div_cell: one restoring-division bit step of the coordinate divider.
// Depends on tpim_pkg.
module tpim_div_cell #(
	parameter int unsigned IDX_W = 32,
	parameter int unsigned SLOT = 0,
	parameter bit LAST = 1'b0
) (
	input  logic clk,
	input  logic arst_n,
	input  tpim_pkg::tpim_div_t in_d,
	input  logic [tpim_pkg::SIZE_W-1:0] divisor,
	input  logic active,
	output tpim_pkg::tpim_div_t out_d
);

	localparam logic [tpim_pkg::WORD_W-1:0] WORD_MASK =
		tpim_pkg::WORD_W'((64'd1 << IDX_W) - 64'd1);

	logic [tpim_pkg::SIZE_W:0] r_sh;
	logic fits;
	logic [tpim_pkg::SIZE_W-1:0] r_nx;
	logic [tpim_pkg::WORD_W-1:0] w_nx;
	tpim_pkg::tpim_div_t nxt;

	logic vld_s1;
	tpim_pkg::tpim_div_t dat_s1;

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		r_sh = {in_d.rem, in_d.word[IDX_W-1]};
		fits = (r_sh >= {1'b0, divisor});
		r_nx = fits ? tpim_pkg::SIZE_W'(r_sh - {1'b0, divisor}) : r_sh[tpim_pkg::SIZE_W-1:0];
		w_nx = {in_d.word[tpim_pkg::WORD_W-2:0], fits};
		nxt = in_d;
		if (active) begin
			nxt.rem = r_nx;
			nxt.word = w_nx;
		end
		// end of a division: park the remainder, keep only the quotient bits
		if (LAST) begin
			nxt.coord[SLOT] = active ? r_nx : '0;
			nxt.rem = '0;
			nxt.word = nxt.word & WORD_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		dat_s1 <= nxt;
	end

	always_comb begin
		out_d = dat_s1;
		out_d.valid = vld_s1;
	end

endmodule

### rtl/core/tpim_horner_step.sv
// tpim_horner_step: one two-stage multiply-add step that folds a source
// axis into the flat input index. Depends on tpim_pkg.
module tpim_horner_step #(
	parameter int unsigned AXIS = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  tpim_pkg::tpim_acc_t in_a,
	input  logic [tpim_pkg::SIZE_W-1:0] factor,
	input  logic active,
	output tpim_pkg::tpim_acc_t out_a
);

	localparam int unsigned HALF_W = tpim_pkg::ACC_W / 2;

	logic [HALF_W+tpim_pkg::SIZE_W-1:0] prod_lo;
	logic [HALF_W+tpim_pkg::SIZE_W-1:0] prod_hi;

	logic vld_s1;
	logic err_s1;
	logic [HALF_W+tpim_pkg::SIZE_W-1:0] p_lo_s1;
	logic [HALF_W-1:0] p_hi_s1;
	logic [tpim_pkg::REG_AXES-1:0][tpim_pkg::CSUM_W-1:0] csum_s1;

	logic vld_s2;
	logic err_s2;
	logic [tpim_pkg::ACC_W-1:0] acc_s2;
	logic [tpim_pkg::REG_AXES-1:0][tpim_pkg::CSUM_W-1:0] csum_s2;
	logic [tpim_pkg::ACC_W-1:0] addend;

	// stage 1: two half-width partial products, only low 64 bits kept
	assign prod_lo = in_a.acc[HALF_W-1:0] * factor;
	assign prod_hi = in_a.acc[tpim_pkg::ACC_W-1:HALF_W] * factor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_a.valid;
			vld_s2 <= vld_s1;
		end
	end

	// stage 2: recombine and add this axis coordinate
	assign addend = active ? tpim_pkg::ACC_W'(csum_s1[AXIS]) : '0;

	always_ff @(posedge clk) begin
		err_s1 <= in_a.err;
		p_lo_s1 <= prod_lo;
		p_hi_s1 <= prod_hi[HALF_W-1:0];
		csum_s1 <= in_a.csum;
		err_s2 <= err_s1;
		acc_s2 <= tpim_pkg::ACC_W'(p_lo_s1) + {p_hi_s1, {HALF_W{1'b0}}} + addend;
		csum_s2 <= csum_s1;
	end

	always_comb begin
		out_a.valid = vld_s2;
		out_a.err = err_s2;
		out_a.acc = acc_s2;
		out_a.csum = csum_s2;
	end

endmodule

### rtl/core/tensor_permute_index_map_top.sv
// tensor_permute_index_map_top: maps a flat output index of a permuted
// tensor to the flat source index. Depends on tpim_pkg, tpim_div_cell and
// tpim_horner_step.
//
// channel  | direction | handshake              | payload
// request  | in        | start, busy            | out_index
// result   | out       | done (one-cycle strobe) | in_index, range_error
// config   | in        | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// A request is taken every cycle; busy is always low. Each request passes
// one divider cell per quotient bit for each of the three inner output
// axes, one merge stage and two stages for each of three multiply-add steps.
// Reset clears the configuration to its defaults and empties the pipeline.
// The receiver cannot stall; results leave on the strobe.
module tensor_permute_index_map_top #(
	parameter int unsigned MAX_DIMS = 4,
	parameter int unsigned INDEX_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [tpim_pkg::WORD_W-1:0] out_index,
	output logic done,
	output logic [tpim_pkg::ACC_W-1:0] in_index,
	output logic range_error,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tpim_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tpim_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned IDX_W =
		(INDEX_BITS < tpim_pkg::WORD_W) ? INDEX_BITS : tpim_pkg::WORD_W;
	localparam int unsigned AXES_CAP =
		(MAX_DIMS < tpim_pkg::REG_AXES) ? MAX_DIMS : tpim_pkg::REG_AXES;
	localparam int unsigned NUM_CELLS = tpim_pkg::NUM_DIVS * IDX_W;
	localparam int unsigned HORNER_LAT = 2 * (tpim_pkg::REG_AXES - 1);
	localparam logic [tpim_pkg::WORD_W-1:0] WORD_MASK =
		tpim_pkg::WORD_W'((64'd1 << IDX_W) - 64'd1);

	// pick the extent of a source axis
	function automatic logic [tpim_pkg::SIZE_W-1:0] pick_size(
		input logic [1:0] sel,
		input logic [tpim_pkg::SIZE_W-1:0] s0,
		input logic [tpim_pkg::SIZE_W-1:0] s1,
		input logic [tpim_pkg::SIZE_W-1:0] s2,
		input logic [tpim_pkg::SIZE_W-1:0] s3
	);
		logic [tpim_pkg::SIZE_W-1:0] r;
		case (sel)
			2'd0: r = s0;
			2'd1: r = s1;
			2'd2: r = s2;
			default: r = s3;
		endcase
		return r;
	endfunction

	logic [2:0] dim_count_q;
	logic [tpim_pkg::SIZE_W-1:0] size0_q;
	logic [tpim_pkg::SIZE_W-1:0] size1_q;
	logic [tpim_pkg::SIZE_W-1:0] size2_q;
	logic [tpim_pkg::SIZE_W-1:0] size3_q;
	logic [7:0] axis_order_q;

	logic [2:0] n_axes;
	logic [tpim_pkg::REG_AXES-1:0][1:0] src;
	logic [tpim_pkg::REG_AXES-1:0][tpim_pkg::SIZE_W-1:0] out_ext;
	logic [tpim_pkg::REG_AXES-1:0][tpim_pkg::SIZE_W-1:0] size_vec;
	logic [tpim_pkg::REG_AXES-1:0] axis_act;

	tpim_pkg::tpim_div_t chain [0:NUM_CELLS];
	tpim_pkg::tpim_div_t last_d;

	logic [tpim_pkg::REG_AXES-1:0][tpim_pkg::SIZE_W-1:0] c_full;
	logic [tpim_pkg::REG_AXES-1:0][tpim_pkg::CSUM_W-1:0] csum;
	logic zero_ext;
	logic err_nx;

	logic merge_vld_s1;
	logic merge_err_s1;
	logic [tpim_pkg::ACC_W-1:0] merge_acc_s1;
	logic [tpim_pkg::REG_AXES-1:0][tpim_pkg::CSUM_W-1:0] merge_csum_s1;

	tpim_pkg::tpim_acc_t hchain [0:tpim_pkg::REG_AXES-1];
	tpim_pkg::tpim_acc_t fin;

	// configuration registers, writable every cycle
	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= tpim_pkg::DIM_COUNT_RST;
			size0_q <= tpim_pkg::SIZE_RST;
			size1_q <= tpim_pkg::SIZE_RST;
			size2_q <= tpim_pkg::SIZE_RST;
			size3_q <= tpim_pkg::SIZE_RST;
			axis_order_q <= tpim_pkg::AXIS_ORDER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tpim_pkg::REG_DIM_COUNT: dim_count_q <= cfg_data[2:0];
				tpim_pkg::REG_SIZE_0: size0_q <= cfg_data;
				tpim_pkg::REG_SIZE_1: size1_q <= cfg_data;
				tpim_pkg::REG_SIZE_2: size2_q <= cfg_data;
				tpim_pkg::REG_SIZE_3: size3_q <= cfg_data;
				tpim_pkg::REG_AXIS_ORDER: axis_order_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// derived shape: axes in use, permuted extents, active axes
	always_comb begin
		n_axes = (dim_count_q > 3'(AXES_CAP)) ? 3'(AXES_CAP) : dim_count_q;
		size_vec = {size3_q, size2_q, size1_q, size0_q};
		for (int d = 0; d < tpim_pkg::REG_AXES; d++) begin
			src[d] = axis_order_q[2*d +: 2];
			out_ext[d] = pick_size(src[d], size0_q, size1_q, size2_q, size3_q);
			axis_act[d] = (3'(d) < n_axes);
		end
	end

	// divider chain entry
	always_comb begin
		chain[0].valid = start && !busy;
		chain[0].word = out_index & WORD_MASK;
		chain[0].rem = '0;
		chain[0].coord = '0;
	end

	// innermost output axis first; each division parks the remainder and passes the quotient on
	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		localparam int unsigned DIV_NO = c / IDX_W;
		localparam int unsigned AX = tpim_pkg::REG_AXES - 1 - DIV_NO;
		tpim_div_cell #(
			.IDX_W(IDX_W),
			.SLOT(DIV_NO),
			.LAST((c % IDX_W) == (IDX_W - 1))
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_d(chain[c]),
			.divisor(out_ext[AX]),
			.active(axis_act[AX]),
			.out_d(chain[c+1])
		);
	end

	assign last_d = chain[NUM_CELLS];

	// merge: range check and coordinates gathered per source axis
	always_comb begin
		c_full[0] = last_d.word[tpim_pkg::SIZE_W-1:0];
		for (int d = 1; d < tpim_pkg::REG_AXES; d++) begin
			c_full[d] = last_d.coord[tpim_pkg::REG_AXES-1-d];
		end
		zero_ext = 1'b0;
		for (int d = 0; d < tpim_pkg::REG_AXES; d++) begin
			zero_ext = zero_ext | (axis_act[d] && (out_ext[d] == '0));
		end
		if (n_axes == 3'd0) begin
			err_nx = (last_d.word != '0);
		end else begin
			err_nx = zero_ext || (last_d.word >= tpim_pkg::WORD_W'(out_ext[0]));
		end
		for (int a = 0; a < tpim_pkg::REG_AXES; a++) begin
			csum[a] = '0;
			for (int d = 0; d < tpim_pkg::REG_AXES; d++) begin
				if (axis_act[d] && (src[d] == 2'(a))) begin
					csum[a] = csum[a] + tpim_pkg::CSUM_W'(c_full[d]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_vld_s1 <= 1'b0;
		end else begin
			merge_vld_s1 <= last_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		merge_err_s1 <= err_nx;
		merge_acc_s1 <= (n_axes != 3'd0) ? tpim_pkg::ACC_W'(csum[0]) : '0;
		merge_csum_s1 <= csum;
	end

	always_comb begin
		hchain[0].valid = merge_vld_s1;
		hchain[0].err = merge_err_s1;
		hchain[0].acc = merge_acc_s1;
		hchain[0].csum = merge_csum_s1;
	end

	// fold in source axes 1..3 by their extents; unused axes pass through
	for (genvar a = 1; a < tpim_pkg::REG_AXES; a++) begin : g_horner
		tpim_horner_step #(
			.AXIS(a)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.in_a(hchain[a-1]),
			.factor(axis_act[a] ? size_vec[a] : tpim_pkg::SIZE_W'(1)),
			.active(axis_act[a]),
			.out_a(hchain[a])
		);
	end

	// result
	assign fin = hchain[tpim_pkg::REG_AXES-1];
	assign done = fin.valid;
	assign range_error = fin.err;
	assign in_index = fin.err ? '0 : fin.acc;

	// a merged request was accepted at the chain entry and passed every divider cell and the merge register
	a_merge_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		merge_vld_s1 |-> $past(start && !busy, NUM_CELLS + 1))
		else $error("merge stage valid without a matching request");

	// every result left the merge stage and then passed the multiply-add steps
	a_done_from_merge: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(merge_vld_s1, HORNER_LAT))
		else $error("result strobe without a merged request");

	// flagged results carry a zero index
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && range_error) |-> (in_index == '0))
		else $error("flagged result with nonzero index");

endmodule
